// File: src/pqtp_pkg.sv
package pqtp_pkg;

  // Field widths fixed by the interface.
  localparam int OP_W     = 2;
  localparam int ID_W     = 8;
  localparam int LVL_W    = 3;
  localparam int ST_W     = 2;
  localparam int RC_W     = 8;
  localparam int TICK_W   = 16;
  localparam int LIM_W    = 8;
  localparam int CFG_IDX_W = 1;

  typedef logic [OP_W-1:0]      opcode_t;
  typedef logic [LVL_W-1:0]     level_t;
  typedef logic [ST_W-1:0]      status_t;
  typedef logic [RC_W-1:0]      run_cnt_t;
  typedef logic [TICK_W-1:0]    tick_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Number of queues and the levels that keep a run count.
  localparam int LEVELS    = 5;
  localparam int RC_LEVELS = 3;

  // Level codes.
  localparam level_t LVL_KERNEL = 3'd0;
  localparam level_t LVL_HIGH   = 3'd1;
  localparam level_t LVL_NORMAL = 3'd2;
  localparam level_t LVL_LOW    = 3'd3;
  localparam level_t LVL_IDLE   = 3'd4;

  // Operation codes.
  localparam opcode_t OP_ENQ  = 2'd0;
  localparam opcode_t OP_TICK = 2'd1;
  localparam opcode_t OP_END  = 2'd2;
  localparam opcode_t OP_NOP  = 2'd3;

  // Status codes.
  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_FULL = 2'd1;
  localparam status_t ST_NONE = 2'd2;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_STARVE = 1'd0;
  localparam cfg_idx_t CFG_SLICE  = 1'd1;

  // Reset values and limits.
  localparam logic [LIM_W-1:0] LIM_RESET   = 8'd4;
  localparam tick_t            SLICE_RESET = 16'd10;
  localparam run_cnt_t         RUN_MAX     = 8'd255;

endpackage

// File: src/pqtp_ram.sv
module pqtp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 80
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port and one read port; the read returns the old contents.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/priority_queue_thread_picker_core.sv
// Thread picker with five FIFO queues (kernel, high, normal, low, idle) feeding one running
// slot. A command word is taken on every cycle with start high and busy low; busy is high
// only in the first cycle after reset. The result word appears with out_valid exactly one
// cycle after its command and cannot be held off, so the receiver must take it then. One
// command per cycle is sustained: the queue memory does one write (enqueue or requeue) and
// one read (the picked head) per command, and the picked ID comes out of the registered
// read port in the cycle after the command, forwarded to the next command if it requeues.

module priority_queue_thread_picker_core
  import pqtp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  opcode_t              in_opcode,
  input  logic [ID_W-1:0]      in_thread_id,
  input  level_t               in_thread_level,
  output logic                 out_valid,
  output logic [ID_W-1:0]      out_running_id,
  output logic                 out_running_valid,
  output level_t               out_running_level,
  output logic                 out_switched,
  output status_t              out_status,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  cfg_idx_t             cfg_index,
  input  logic [TICK_W-1:0]    cfg_data
);

  localparam int SW   = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int HW   = $clog2(QUEUE_DEPTH);
  localparam int SUMW = CW + 1;
  localparam int AW   = $clog2(LEVELS * QUEUE_DEPTH);

  // State registers.
  logic [HW-1:0]    heads_r  [LEVELS];
  logic [CW-1:0]    counts_r [LEVELS];
  run_cnt_t         rc_r     [RC_LEVELS];
  tick_t            tick_r;
  logic [SW-1:0]    cur_id_r;
  level_t           level_r;
  logic             present_r;
  logic             pop_pend_r;
  logic             byp_r;
  logic [SW-1:0]    byp_id_r;
  logic [LIM_W-1:0] lim_r;
  tick_t            slice_r;
  logic             busy_r;
  logic             out_valid_r;
  logic             switched_r;
  status_t          status_r;

  // Next values and per-command decode.
  logic [HW-1:0]    heads_nxt  [LEVELS];
  logic [CW-1:0]    counts_nxt [LEVELS];
  logic [CW-1:0]    counts_a   [LEVELS];
  run_cnt_t         rc_nxt     [RC_LEVELS];
  run_cnt_t         rc_a       [RC_LEVELS];
  logic [HW-1:0]    tail       [LEVELS];
  logic [SUMW-1:0]  tail_sum   [LEVELS];
  logic [LEVELS-1:0] full_v;
  logic [LEVELS-1:0] nz;
  logic [LEVELS-1:0] push_hit;
  logic [LEVELS-1:0] pop_hit;
  logic [LEVELS-1:0] cnt_ovf;
  logic [RC_LEVELS-1:0] lim_hit;
  tick_t            tick_nxt;
  tick_t            tick_inc;
  tick_t            slice_eff;
  level_t           level_nxt;
  logic             present_nxt;
  logic             present_p;
  logic             accept;
  logic             do_pick;
  logic             pick_go;
  logic             want_push;
  logic             push_en;
  logic             push_full;
  level_t           push_lv;
  logic [SW-1:0]    push_id;
  logic             pop_en;
  level_t           sel;
  logic             any_q;
  logic             sw;
  status_t          st;
  logic [SW-1:0]    cur_id_eff;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    rd_addr;
  logic [SW-1:0]    rd_data;

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = !busy_r;

  // The ID of the running thread comes from the memory right after a pick.
  assign cur_id_eff = pop_pend_r ? (byp_r ? byp_id_r : rd_data) : cur_id_r;

  // Queue memory: one row of QUEUE_DEPTH entries per level.
  pqtp_ram #(
    .WIDTH(SW),
    .DEPTH(LEVELS * QUEUE_DEPTH)
  ) u_qmem (
    .clk    (clk),
    .wr_en  (push_en),
    .wr_addr(wr_addr),
    .wr_data(push_id),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Command decode, requeue or enqueue, level selection and pop.
  always_comb begin
    tick_nxt    = tick_r;
    level_nxt   = level_r;
    present_nxt = present_r;
    present_p   = present_r;
    do_pick     = 1'b0;
    pick_go     = 1'b0;
    want_push   = 1'b0;
    push_lv     = in_thread_level;
    push_id     = in_thread_id[SW-1:0];
    st          = ST_OK;
    sw          = 1'b0;
    pop_en      = 1'b0;
    sel         = LVL_IDLE;
    tick_inc    = tick_r + 16'd1;
    slice_eff   = (slice_r == '0) ? 16'd1 : slice_r;
    any_q       = 1'b0;

    for (int l = 0; l < LEVELS; l++) begin
      any_q     = any_q | (counts_r[l] != '0);
      full_v[l] = (counts_r[l] == CW'(QUEUE_DEPTH));
    end

    if (accept) begin
      unique case (in_opcode)
        OP_ENQ: begin
          want_push = (in_thread_level <= LVL_IDLE);
        end
        OP_TICK: begin
          if (tick_inc >= slice_eff) begin
            tick_nxt = '0;
            do_pick  = 1'b1;
          end else begin
            tick_nxt = tick_inc;
          end
        end
        OP_END: begin
          present_p   = 1'b0;
          present_nxt = 1'b0;
          tick_nxt    = '0;
          do_pick     = 1'b1;
        end
        OP_NOP: begin
        end
        default: begin
        end
      endcase
    end

    // Empty system reports an error; a lone running thread keeps running.
    if (do_pick) begin
      if (!any_q) begin
        if (!present_p) begin
          st          = ST_NONE;
          present_nxt = 1'b0;
        end
      end else begin
        pick_go = 1'b1;
        sw      = 1'b1;
        if (present_p) begin
          want_push = 1'b1;
          push_lv   = level_r;
          push_id   = cur_id_eff;
        end
      end
    end

    // The push lands at the tail of its level unless that queue is full.
    push_full = 1'b0;
    for (int l = 0; l < LEVELS; l++) begin
      push_full = push_full | (full_v[l] && (push_lv == LVL_W'(l)));
    end
    push_en = want_push && !push_full;
    if (want_push && push_full) begin
      st = ST_FULL;
    end

    for (int l = 0; l < LEVELS; l++) begin
      push_hit[l] = push_en && (push_lv == LVL_W'(l));
      counts_a[l] = counts_r[l] + CW'(push_hit[l]);
      nz[l]       = (counts_a[l] != '0);
      tail_sum[l] = SUMW'(heads_r[l]) + SUMW'(counts_r[l]);
      tail[l]     = (tail_sum[l] >= SUMW'(QUEUE_DEPTH)) ?
                    HW'(tail_sum[l] - SUMW'(QUEUE_DEPTH)) : HW'(tail_sum[l]);
    end

    // The requeued thread counts one more run at its level.
    for (int l = 0; l < RC_LEVELS; l++) begin
      rc_a[l] = rc_r[l];
      if (pick_go && present_p && (level_r == LVL_W'(l)) && (rc_r[l] != RUN_MAX)) begin
        rc_a[l] = rc_r[l] + 8'd1;
      end
      lim_hit[l] = (rc_a[l] >= lim_r);
      rc_nxt[l]  = rc_a[l];
    end

    // Kernel, high and normal give way to the levels below, down to low, once the run count reaches the limit.
    if (pick_go) begin
      pop_en      = 1'b1;
      present_nxt = 1'b1;
      if ((lim_hit[0] || !nz[0]) && (nz[1] || nz[2] || nz[3])) begin
        rc_nxt[0] = '0;
        if ((lim_hit[1] || !nz[1]) && (nz[2] || nz[3])) begin
          rc_nxt[1] = '0;
          if ((lim_hit[2] || !nz[2]) && nz[3]) begin
            sel       = LVL_LOW;
            rc_nxt[2] = '0;
          end else begin
            sel = LVL_NORMAL;
          end
        end else begin
          sel = LVL_HIGH;
        end
      end else if (nz[0]) begin
        sel = LVL_KERNEL;
      end else begin
        sel = LVL_IDLE;
      end
      level_nxt = sel;
    end

    // Head and count updates and memory addresses.
    wr_addr = '0;
    rd_addr = '0;
    for (int l = 0; l < LEVELS; l++) begin
      pop_hit[l]    = pop_en && (sel == LVL_W'(l));
      counts_nxt[l] = counts_a[l] - CW'(pop_hit[l]);
      cnt_ovf[l]    = (counts_r[l] > CW'(QUEUE_DEPTH));
      heads_nxt[l]  = heads_r[l];
      if (pop_hit[l]) begin
        heads_nxt[l] = (heads_r[l] == HW'(QUEUE_DEPTH - 1)) ? '0 : heads_r[l] + 1'b1;
        rd_addr      = rd_addr | (AW'(l * QUEUE_DEPTH) + AW'(heads_r[l]));
      end
      if (push_hit[l]) begin
        wr_addr = wr_addr | (AW'(l * QUEUE_DEPTH) + AW'(tail[l]));
      end
    end
  end

  // State update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < LEVELS; l++) begin
        heads_r[l]  <= '0;
        counts_r[l] <= '0;
      end
      for (int l = 0; l < RC_LEVELS; l++) begin
        rc_r[l] <= '0;
      end
      tick_r      <= '0;
      cur_id_r    <= '0;
      level_r     <= LVL_KERNEL;
      present_r   <= 1'b0;
      pop_pend_r  <= 1'b0;
      byp_r       <= 1'b0;
      lim_r       <= LIM_RESET;
      slice_r     <= SLICE_RESET;
      busy_r      <= 1'b1;
      out_valid_r <= 1'b0;
      switched_r  <= 1'b0;
      status_r    <= ST_OK;
    end else begin
      for (int l = 0; l < LEVELS; l++) begin
        heads_r[l]  <= heads_nxt[l];
        counts_r[l] <= counts_nxt[l];
      end
      for (int l = 0; l < RC_LEVELS; l++) begin
        rc_r[l] <= rc_nxt[l];
      end
      tick_r      <= tick_nxt;
      cur_id_r    <= cur_id_eff;
      level_r     <= level_nxt;
      present_r   <= present_nxt;
      pop_pend_r  <= pop_en;
      // A requeue into an empty queue that is picked at once reads its own write.
      byp_r       <= push_en && pop_en && (wr_addr == rd_addr);
      busy_r      <= 1'b0;
      out_valid_r <= accept;
      if (accept) begin
        switched_r <= sw;
        status_r   <= st;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_STARVE: lim_r   <= cfg_data[LIM_W-1:0];
          CFG_SLICE:  slice_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Bypass data for the same-entry case.
  always_ff @(posedge clk) begin
    byp_id_r <= push_id;
  end

  // Result word: the running thread as left by the command.
  assign out_valid         = out_valid_r;
  assign out_running_valid = present_r;
  assign out_running_level = present_r ? level_r : LVL_KERNEL;
  assign out_running_id    = present_r ? ID_W'(cur_id_eff) : '0;
  assign out_switched      = switched_r;
  assign out_status        = status_r;

`ifndef ASSERT_OFF
  a_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_ovf == '0)
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop_en |-> ((pop_hit & nz) != '0))
    else $error("pick from an empty queue");

  a_none_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_NONE)) |-> (!out_running_valid && !out_switched))
    else $error("no-thread status with a thread running");

  a_switch_runs: assert property (@(posedge clk) disable iff (!rst_n)
    pop_en |=> (present_r && pop_pend_r))
    else $error("pick did not start a thread");
`endif

endmodule
